/* rtl/core/psl_pkg.sv */
// shared types and constants for the positional sequence list
package psl_pkg;

  localparam int unsigned DEPTH  = 32;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W  = $clog2(DEPTH);

  typedef enum logic [2:0] {
    OP_INS_FIRST = 3'd0,
    OP_INS_LAST  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_FIRST = 3'd3,
    OP_DEL_LAST  = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_DUMP_FWD  = 3'd6,
    OP_DUMP_REV  = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  // what a cell loads on the next edge
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_PREV,
    CELL_NEXT,
    CELL_WRAP
  } cell_op_e;

endpackage

/* rtl/core/psl_if.sv */
// request and response channel interfaces
interface psl_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [31:0] value;
  logic [5:0]  position;

  modport source (output valid, output operation, output value, output position,
                  input ready);
  modport sink (input valid, input operation, input value, input position,
                output ready);
endinterface

interface psl_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [5:0]  element_count;
  logic [31:0] element_value;
  logic        last;

  modport source (output valid, output status, output element_count,
                  output element_value, output last, input ready);
  modport sink (input valid, input status, input element_count,
                input element_value, input last, output ready);
endinterface

/* rtl/core/positional_sequence_list.sv */
// top level: bounded ordered list built as a chain of shifting cells
//
//   channel  dir  payload                                         per request
//   req_i    in   operation, value, position                      one item
//   rsp_o    out  status, element_count, element_value, last      1 or count results
//
// an insert or delete completes on its accepting edge: every cell at or past the slot shifts
// on that edge and the result is registered on that same edge, so edits can follow every cycle
// while the response side keeps taking results. a dump first enters the dump state, then rotates
// the occupied cells by one per cycle while the response is taken and sends the head (or tail)
// word each time; it holds the request side until the last word is sent and leaves the list
// unchanged. reset clears the count, the control and the output register; cell contents are
// left as they are. a stalled response holds its payload and freezes the rotation.
module positional_sequence_list (
  input  logic       clk_i,
  input  logic       rst_ni,
  psl_req_if.sink    req_i,
  psl_rsp_if.source  rsp_o
);

  localparam int unsigned DEPTH = psl_pkg::DEPTH;
  localparam int unsigned DW    = psl_pkg::DATA_W;
  localparam int unsigned CW    = psl_pkg::CNT_W;
  localparam int unsigned IW    = psl_pkg::IDX_W;
  // width that holds both a position and count + 1 for compares
  localparam int unsigned PW    = ((CW > 6) ? CW : 6) + 1;

  typedef enum logic {
    CTL_IDLE,
    CTL_DUMP
  } ctl_state_e;

  ctl_state_e st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] dmp_q, dmp_d;
  logic          rev_q, rev_d;

  logic          out_valid_q, out_valid_d;
  logic [1:0]    out_status_q, out_status_d;
  logic [5:0]    out_count_q, out_count_d;
  logic [31:0]   out_value_q, out_value_d;
  logic          out_last_q, out_last_d;

  psl_pkg::cell_op_e cell_op [DEPTH];
  logic [DW-1:0]     cell_word [DEPTH];
  logic [DW-1:0]     new_word;
  logic [DW-1:0]     tail_word;
  logic [CW-1:0]     cnt_m1;

  logic          out_free;
  logic          req_ready;
  logic          req_fire;
  psl_pkg::op_e  req_op;
  logic [PW-1:0] pos_x;
  logic [PW-1:0] cnt_x;
  logic [CW-1:0] ins_idx;
  logic [CW-1:0] del_idx;
  logic          full;
  logic          empty;
  logic          dump_last;

  // the cell chain
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DW-1:0] prev_w;
    logic [DW-1:0] next_w;
    logic [DW-1:0] wrap_w;

    if (g == 0) begin : g_head
      assign prev_w = '0;
      assign wrap_w = tail_word;
    end else begin : g_body
      assign prev_w = cell_word[g-1];
      assign wrap_w = cell_word[0];
    end

    if (g == DEPTH - 1) begin : g_end
      assign next_w = '0;
    end else begin : g_mid
      assign next_w = cell_word[g+1];
    end

    psl_cell u_cell (
      .clk_i  (clk_i),
      .op_i   (cell_op[g]),
      .load_i (new_word),
      .prev_i (prev_w),
      .next_i (next_w),
      .wrap_i (wrap_w),
      .word_o (cell_word[g])
    );
  end

  assign new_word  = DW'(req_i.value);
  assign cnt_m1    = cnt_q - CW'(1);
  assign tail_word = cell_word[cnt_m1[IW-1:0]];

  assign out_free  = !out_valid_q || rsp_o.ready;
  assign req_ready = (st_q == CTL_IDLE) && out_free;
  assign req_fire  = req_i.valid && req_ready;
  assign req_op    = psl_pkg::op_e'(req_i.operation);

  assign pos_x     = PW'(req_i.position);
  assign cnt_x     = PW'(cnt_q);
  assign full      = (cnt_q == CW'(DEPTH));
  assign empty     = (cnt_q == '0);
  assign dump_last = (CW'(dmp_q) == cnt_m1);

  // slot for the insert or delete, 0-based
  always_comb begin
    case (req_op)
      psl_pkg::OP_INS_FIRST: ins_idx = '0;
      psl_pkg::OP_INS_LAST:  ins_idx = cnt_q;
      default:               ins_idx = CW'(pos_x - PW'(1));
    endcase
    case (req_op)
      psl_pkg::OP_DEL_FIRST: del_idx = '0;
      psl_pkg::OP_DEL_LAST:  del_idx = cnt_m1;
      default:               del_idx = CW'(pos_x - PW'(1));
    endcase
  end

  always_comb begin
    st_d         = st_q;
    cnt_d        = cnt_q;
    dmp_d        = dmp_q;
    rev_d        = rev_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    out_value_d  = out_value_q;
    out_last_d   = out_last_q;
    for (int i = 0; i < DEPTH; i++) begin
      cell_op[i] = psl_pkg::CELL_HOLD;
    end

    unique case (st_q)
      CTL_IDLE: begin
        if (req_fire) begin
          out_valid_d  = 1'b1;
          out_status_d = psl_pkg::ST_OK;
          out_value_d  = '0;
          out_last_d   = 1'b1;
          case (req_op) inside
            psl_pkg::OP_INS_FIRST, psl_pkg::OP_INS_LAST, psl_pkg::OP_INS_AT: begin
              if (full) begin
                out_status_d = psl_pkg::ST_FULL;
              end else if (req_op == psl_pkg::OP_INS_AT &&
                           (pos_x == '0 || pos_x > cnt_x + PW'(1))) begin
                out_status_d = psl_pkg::ST_BADPOS;
              end else begin
                // open a gap at the slot: cells past it take from the left
                for (int i = 0; i < DEPTH; i++) begin
                  if (CW'(i) == ins_idx) begin
                    cell_op[i] = psl_pkg::CELL_LOAD;
                  end else if (CW'(i) > ins_idx) begin
                    cell_op[i] = psl_pkg::CELL_PREV;
                  end
                end
                cnt_d = cnt_q + CW'(1);
              end
            end
            psl_pkg::OP_DEL_FIRST, psl_pkg::OP_DEL_LAST, psl_pkg::OP_DEL_AT: begin
              if (empty) begin
                out_status_d = psl_pkg::ST_EMPTY;
              end else if (req_op == psl_pkg::OP_DEL_AT &&
                           (pos_x == '0 || pos_x > cnt_x)) begin
                out_status_d = psl_pkg::ST_BADPOS;
              end else begin
                // close the gap: cells from the slot on take from the right
                for (int i = 0; i < DEPTH; i++) begin
                  if (CW'(i) >= del_idx) begin
                    cell_op[i] = psl_pkg::CELL_NEXT;
                  end
                end
                cnt_d = cnt_m1;
              end
            end
            default: begin
              if (empty) begin
                out_status_d = psl_pkg::ST_EMPTY;
              end else begin
                // dump results come from the rotation loop
                out_valid_d = out_valid_q && !rsp_o.ready;
                st_d        = CTL_DUMP;
                dmp_d       = '0;
                rev_d       = (req_op == psl_pkg::OP_DUMP_REV);
              end
            end
          endcase
          out_count_d = 6'(cnt_d);
        end
      end
      CTL_DUMP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = psl_pkg::ST_OK;
          out_count_d  = 6'(cnt_q);
          out_last_d   = dump_last;
          if (rev_q) begin
            // send the tail, rotate right over the occupied cells
            out_value_d = 32'($signed(tail_word));
            for (int i = 0; i < DEPTH; i++) begin
              if (i == 0) begin
                cell_op[i] = psl_pkg::CELL_WRAP;
              end else if (CW'(i) < cnt_q) begin
                cell_op[i] = psl_pkg::CELL_PREV;
              end
            end
          end else begin
            // send the head, rotate left over the occupied cells
            out_value_d = 32'($signed(cell_word[0]));
            for (int i = 0; i < DEPTH; i++) begin
              if (CW'(i) == cnt_m1) begin
                cell_op[i] = psl_pkg::CELL_WRAP;
              end else if (CW'(i) < cnt_m1) begin
                cell_op[i] = psl_pkg::CELL_NEXT;
              end
            end
          end
          dmp_d = dmp_q + IW'(1);
          if (dump_last) begin
            st_d = CTL_IDLE;
          end
        end
      end
      default: begin
        st_d = CTL_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= CTL_IDLE;
      cnt_q        <= '0;
      dmp_q        <= '0;
      rev_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_count_q  <= '0;
      out_value_q  <= '0;
      out_last_q   <= 1'b0;
    end else begin
      st_q         <= st_d;
      cnt_q        <= cnt_d;
      dmp_q        <= dmp_d;
      rev_q        <= rev_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_count_q  <= out_count_d;
      out_value_q  <= out_value_d;
      out_last_q   <= out_last_d;
    end
  end

  assign req_i.ready         = req_ready;
  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.element_count = out_count_q;
  assign rsp_o.element_value = out_value_q;
  assign rsp_o.last          = out_last_q;

endmodule

/* rtl/core/psl_cell.sv */
// one list cell: a data word that loads from a neighbor, new data or the wrap path
module psl_cell (
  input  logic                        clk_i,
  input  psl_pkg::cell_op_e           op_i,
  input  logic [psl_pkg::DATA_W-1:0]  load_i,
  input  logic [psl_pkg::DATA_W-1:0]  prev_i,
  input  logic [psl_pkg::DATA_W-1:0]  next_i,
  input  logic [psl_pkg::DATA_W-1:0]  wrap_i,
  output logic [psl_pkg::DATA_W-1:0]  word_o
);

  logic [psl_pkg::DATA_W-1:0] word_q;
  logic [psl_pkg::DATA_W-1:0] word_d;

  always_comb begin
    case (op_i)
      psl_pkg::CELL_LOAD: word_d = load_i;
      psl_pkg::CELL_PREV: word_d = prev_i;
      psl_pkg::CELL_NEXT: word_d = next_i;
      psl_pkg::CELL_WRAP: word_d = wrap_i;
      default:            word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule
